// File: rtl/cbws_pkg.sv
// Package for the character box word segmenter: payload structs, constants
// and the small box and gap helper functions shared by the RTL modules.
// No dependencies.
package cbws_pkg;

    localparam int CoordW = 12;
    localparam int ExtW   = 13;
    localparam int GapW   = 14;
    localparam int CntW   = 8;
    localparam int Slots  = 3;
    localparam int SlotCntW = 2;

    localparam logic signed [GapW-1:0] LONE_GAP     = 14'sd1000;
    localparam logic [CntW-1:0]        MARGIN_RESET = 8'd2;
    localparam logic [CntW-1:0]        COUNT_MAX    = 8'd255;

    // Register byte address of gap_margin.
    localparam logic [2:0] ADDR_GAP_MARGIN = 3'd0;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] w;
        logic [CoordW-1:0] h;
        logic              line_end;
    } t_char;

    typedef struct packed {
        logic [CoordW-1:0] left;
        logic [CoordW-1:0] top;
        logic [ExtW-1:0]   right;
        logic [ExtW-1:0]   bottom;
        logic [CntW-1:0]   count;
    } t_box;

    typedef struct packed {
        logic [CoordW-1:0] left;
        logic [CoordW-1:0] top;
        logic [ExtW-1:0]   width;
        logic [ExtW-1:0]   height;
        logic [CntW-1:0]   chars;
        logic              last;
    } t_word;

    // Words produced by one character box, packed from slot 0 upward.
    typedef struct packed {
        t_word [Slots-1:0]   slot;
        logic [SlotCntW-1:0] cnt;
    } t_res_set;

    // Merge one character box into a word, or start a new word with it.
    function automatic t_box f_add_box(input logic open, input t_box b, input t_char c);
        t_box             res;
        logic [ExtW-1:0]  r;
        logic [ExtW-1:0]  bt;
        r  = {1'b0, c.x} + {1'b0, c.w};
        bt = {1'b0, c.y} + {1'b0, c.h};
        if (!open) begin
            res.left   = c.x;
            res.top    = c.y;
            res.right  = r;
            res.bottom = bt;
            res.count  = 8'd1;
        end else begin
            res.left   = (c.x < b.left) ? c.x : b.left;
            res.top    = (c.y < b.top) ? c.y : b.top;
            res.right  = (r > b.right) ? r : b.right;
            res.bottom = (bt > b.bottom) ? bt : b.bottom;
            res.count  = (b.count < COUNT_MAX) ? b.count + 8'd1 : b.count;
        end
        return res;
    endfunction

    // A word break stands before a box whose gap beats either neighbor gap
    // by more than the margin. Gaps are signed.
    function automatic logic f_is_break(
        input logic signed [GapW-1:0] cur,
        input logic signed [GapW-1:0] prev,
        input logic signed [GapW-1:0] next,
        input logic [CntW-1:0]        margin
    );
        logic signed [GapW:0] c;
        logic signed [GapW:0] p;
        logic signed [GapW:0] n;
        logic signed [GapW:0] m;
        c = {cur[GapW-1], cur};
        p = {prev[GapW-1], prev};
        n = {next[GapW-1], next};
        m = {7'b0, margin};
        return (c > p + m) || (c > n + m);
    endfunction

    function automatic t_word f_to_word(input t_box b, input logic last);
        t_word res;
        res.left   = b.left;
        res.top    = b.top;
        res.width  = b.right - {1'b0, b.left};
        res.height = b.bottom - {1'b0, b.top};
        res.chars  = b.count;
        res.last   = last;
        return res;
    endfunction

endpackage

// File: rtl/cbws_core.sv
// Segmenter state and decision logic: the held box, gap history and the open
// word's union box. Produces up to three words per box. Uses cbws_pkg.
module cbws_core
    import cbws_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_proc,
    input  t_char            i_char,
    input  logic [CntW-1:0]  i_margin,
    output t_res_set         o_res
);

    logic                    r_held_valid;
    t_char                   r_held;
    logic signed [GapW-1:0]  r_held_gap;
    logic signed [GapW-1:0]  r_before_gap;
    logic                    r_word_open;
    t_box                    r_box;

    logic [ExtW-1:0]         held_right;
    logic signed [GapW-1:0]  gap;
    logic                    v1;
    logic                    v2;
    logic                    v3;
    t_box                    a_box;
    logic                    a_open;
    logic signed [GapW-1:0]  a_before;
    logic signed [GapW-1:0]  next_gap;
    t_box                    b_box;
    t_word                   w1;
    t_word                   w2;
    t_word                   w3;

    always_comb begin
        held_right = {1'b0, r_held.x} + {1'b0, r_held.w};
        gap = r_held_valid ? ({2'b0, i_char.x} - {1'b0, held_right}) : '0;

        // The held box now knows its right neighbor: decide its break.
        v1 = r_held_valid && r_word_open
             && f_is_break(r_held_gap, r_before_gap, gap, i_margin);
        a_box    = r_held_valid ? f_add_box(r_word_open && !v1, r_box, r_held) : r_box;
        a_open   = r_held_valid || r_word_open;
        a_before = r_held_valid ? r_held_gap : r_before_gap;

        // At the line end the incoming box is decided and flushed at once.
        next_gap = r_held_valid ? gap : LONE_GAP;
        v2 = i_char.line_end && a_open && f_is_break(gap, a_before, next_gap, i_margin);
        v3 = i_char.line_end;
        b_box = f_add_box(a_open && !v2, a_box, i_char);

        w1 = f_to_word(r_box, 1'b0);
        w2 = f_to_word(a_box, 1'b0);
        w3 = f_to_word(b_box, 1'b1);

        o_res.slot[0] = v1 ? w1 : (v2 ? w2 : w3);
        o_res.slot[1] = (v1 && v2) ? w2 : w3;
        o_res.slot[2] = w3;
        o_res.cnt = {1'b0, v1} + {1'b0, v2} + {1'b0, v3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_word_open  <= 1'b0;
            r_before_gap <= LONE_GAP;
        end else if (i_proc) begin
            if (i_char.line_end) begin
                r_held_valid <= 1'b0;
                r_word_open  <= 1'b0;
                r_before_gap <= LONE_GAP;
            end else begin
                r_held_valid <= 1'b1;
                r_word_open  <= a_open;
                r_before_gap <= a_before;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_proc && !i_char.line_end) begin
            r_held     <= i_char;
            r_held_gap <= gap;
            r_box      <= a_box;
        end
    end

`ifndef NO_ASSERTIONS
    a_line_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_proc && i_char.line_end |=> !r_held_valid && !r_word_open)
        else $error("line end did not clear the held box");

    a_fresh_line_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held_valid |-> r_before_gap == LONE_GAP)
        else $error("gap history not reset at line start");

    a_word_needs_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_open |-> r_held_valid)
        else $error("open word without a held box");
`endif

endmodule

// File: rtl/cbws_outq.sv
// Result slots of the word segmenter: loads up to three words at once and
// hands them out one per transfer, slot 0 first. Uses cbws_pkg.
module cbws_outq
    import cbws_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_res_set            i_set,
    input  logic                i_pop,
    output logic [SlotCntW-1:0] o_cnt,
    output t_word               o_word
);

    t_word [Slots-1:0]   r_slot;
    logic [SlotCntW-1:0] r_cnt;
    logic [SlotCntW-1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_set.cnt;
        end else if (i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_set.slot;
        end else if (i_pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    assign o_cnt  = r_cnt;
    assign o_word = r_slot[0];

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3 || !i_load)
        else $error("result slots loaded while still full");
`endif

endmodule

// File: rtl/char_box_word_segmenter_unit.sv
// Top level of the character box word segmenter: input register, APB
// register port, segmenter core and result slots. Uses cbws_pkg,
// cbws_core and cbws_outq.
//
// Usage: character boxes of one text line enter left to right on the input
// channel (i_in_valid / o_in_ready), one box per transfer, with i_line_end
// set on the last box of the line. Words leave on the output channel
// (o_out_valid / i_out_ready) as union bounding boxes with a character
// count; o_last_word marks the word flushed by the line end.
// Each box is held back until its successor arrives, because the break
// decision needs the gap on both sides. A word is presented once the box
// that closes it, or the line-end box, has passed the input register and
// the segmenter logic has loaded the result slots.
// Throughput is one box per cycle while the receiver is ready. One box may
// close up to three words; the three result slots then drain one word per
// cycle while the receiver is ready, and the input register waits until the
// slots are empty or empty this cycle.
// When the receiver stalls, the pending word holds on the outputs, the
// input register fills and o_in_ready drops until words move again.
// Reset (synchronous, active low) empties the slots and input register,
// clears any partial line and sets gap_margin to 2. gap_margin sits at
// byte address 0 and should only be written while the block is idle.
module char_box_word_segmenter_unit
    import cbws_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CoordW-1:0] i_char_x,
    input  logic [CoordW-1:0] i_char_y,
    input  logic [CoordW-1:0] i_char_width,
    input  logic [CoordW-1:0] i_char_height,
    input  logic              i_line_end,

    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CoordW-1:0] o_word_left,
    output logic [CoordW-1:0] o_word_top,
    output logic [ExtW-1:0]   o_word_width,
    output logic [ExtW-1:0]   o_word_height,
    output logic [CntW-1:0]   o_word_chars,
    output logic              o_last_word,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [CntW-1:0]     r_gap_margin;
    logic                r_in_valid;
    t_char               r_in;
    logic                proc;
    logic                pop;
    logic [SlotCntW-1:0] slot_cnt;
    t_res_set            res_set;
    t_word               word;

    // Configuration: register writes complete in the APB access phase.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_GAP_MARGIN) ? {24'b0, r_gap_margin} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_margin <= MARGIN_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_GAP_MARGIN) begin
            r_gap_margin <= pwdata[CntW-1:0];
        end
    end

    // The registered box moves into the segmenter once the result slots are
    // empty, or hold a single word that leaves in this same cycle.
    assign pop  = o_out_valid && i_out_ready;
    assign proc = r_in_valid
                  && (slot_cnt == 2'd0 || (slot_cnt == 2'd1 && i_out_ready));
    assign o_in_ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.x        <= i_char_x;
            r_in.y        <= i_char_y;
            r_in.w        <= i_char_width;
            r_in.h        <= i_char_height;
            r_in.line_end <= i_line_end;
        end
    end

    cbws_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_proc   (proc),
        .i_char   (r_in),
        .i_margin (r_gap_margin),
        .o_res    (res_set)
    );

    cbws_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (proc),
        .i_set   (res_set),
        .i_pop   (pop),
        .o_cnt   (slot_cnt),
        .o_word  (word)
    );

    assign o_out_valid   = slot_cnt != 2'd0;
    assign o_word_left   = word.left;
    assign o_word_top    = word.top;
    assign o_word_width  = word.width;
    assign o_word_height = word.height;
    assign o_word_chars  = word.chars;
    assign o_last_word   = word.last;

`ifndef NO_ASSERTIONS
    a_word_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_word_chars != 8'd0)
        else $error("empty word presented");

    a_proc_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> slot_cnt == $past(res_set.cnt))
        else $error("result slots lost or kept stale words");
`endif

endmodule

// File: sim/char_box_word_segmenter_unit_tb.sv
// Self-checking testbench for char_box_word_segmenter_unit: directed rows,
// then random text lines, with words checked against a local word predictor.
// Depends on cbws_pkg and the char_box_word_segmenter_unit RTL only.
module char_box_word_segmenter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbws_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    // Receiver hold-off long enough to fill the input register and all
    // three result slots, so o_in_ready has to drop.
    localparam int HOLD_CYCLES  = 64;
    // Cycles without any transfer on either channel before giving up.
    localparam int QUIET_LIMIT  = 2000;
    // A word leaves once its closing box has passed both registers; allow margin.
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 36;

    // One row of the directed table. Rows with typed set carry the word
    // that must come out, written by hand; the rest use the predictor.
    typedef struct packed {
        t_char box;
        logic  typed;
        t_word word;
    } t_seg_row;

    localparam int NUM_ROWS = 20;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [CoordW-1:0] i_char_x = '0;
    logic [CoordW-1:0] i_char_y = '0;
    logic [CoordW-1:0] i_char_width = '0;
    logic [CoordW-1:0] i_char_height = '0;
    logic              i_line_end = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [CoordW-1:0] o_word_left;
    logic [CoordW-1:0] o_word_top;
    logic [ExtW-1:0]   o_word_width;
    logic [ExtW-1:0]   o_word_height;
    logic [CntW-1:0]   o_word_chars;
    logic              o_last_word;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Directed table. The first two rows are one-box lines at the field
    // extremes, so the word is simply the box itself.
    t_seg_row seg_rows [0:NUM_ROWS-1] = '{
        // One-box line, everything zero.
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b1}, 1'b1,
          '{12'd0, 12'd0, 13'd0, 13'd0, 8'd1, 1'b1}},
        // One-box line, everything at its maximum.
        '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1}, 1'b1,
          '{12'd4095, 12'd4095, 13'd4095, 13'd4095, 8'd1, 1'b1}},
        // Evenly spaced line that stays one word.
        '{'{12'd10, 12'd20, 12'd8, 12'd12, 1'b0}, 1'b0, '0},
        '{'{12'd20, 12'd22, 12'd8, 12'd10, 1'b0}, 1'b0, '0},
        '{'{12'd30, 12'd18, 12'd8, 12'd12, 1'b1}, 1'b0, '0},
        // Wide gap in the middle splits the line into two words.
        '{'{12'd100, 12'd40, 12'd10, 12'd10, 1'b0}, 1'b0, '0},
        '{'{12'd112, 12'd40, 12'd10, 12'd10, 1'b0}, 1'b0, '0},
        '{'{12'd124, 12'd40, 12'd10, 12'd10, 1'b0}, 1'b0, '0},
        '{'{12'd160, 12'd40, 12'd10, 12'd10, 1'b0}, 1'b0, '0},
        '{'{12'd172, 12'd40, 12'd10, 12'd10, 1'b1}, 1'b0, '0},
        // First box overlaps its successor by far more than the margin:
        // the break lands with no word open and nothing is emitted for it.
        '{'{12'd200, 12'd50, 12'd50, 12'd10, 1'b0}, 1'b0, '0},
        '{'{12'd210, 12'd50, 12'd10, 12'd10, 1'b0}, 1'b0, '0},
        '{'{12'd222, 12'd50, 12'd10, 12'd10, 1'b1}, 1'b0, '0},
        // Overlapping boxes all along the line, so every gap is negative.
        '{'{12'd300, 12'd60, 12'd20, 12'd20, 1'b0}, 1'b0, '0},
        '{'{12'd315, 12'd60, 12'd20, 12'd20, 1'b0}, 1'b0, '0},
        '{'{12'd330, 12'd60, 12'd20, 12'd20, 1'b0}, 1'b0, '0},
        '{'{12'd345, 12'd60, 12'd20, 12'd20, 1'b1}, 1'b0, '0},
        // Growing gaps: the line-end box closes three words at once.
        '{'{12'd0, 12'd100, 12'd5, 12'd5, 1'b0}, 1'b0, '0},
        '{'{12'd100, 12'd100, 12'd5, 12'd5, 1'b0}, 1'b0, '0},
        '{'{12'd300, 12'd100, 12'd5, 12'd5, 1'b1}, 1'b0, '0}
    };

    // Predictor state: the parked box waiting for its successor, the gap
    // history and the word under construction.
    logic [CntW-1:0]        margin_now;
    logic                   parked_live;
    t_char                  parked_box;
    logic signed [GapW-1:0] parked_gap;
    logic signed [GapW-1:0] prior_gap;
    logic                   word_live;
    t_box                   word_acc;

    // Words still owed by the block, oldest first.
    t_word words_due [$];

    int fail_count = 0;
    int quiet_cycles = 0;
    // calm switches off idling on both sides; hold_req asks the receiver
    // for one long hold-off.
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    char_box_word_segmenter_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_x      (i_char_x),
        .i_char_y      (i_char_y),
        .i_char_width  (i_char_width),
        .i_char_height (i_char_height),
        .i_line_end    (i_line_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_word_left   (o_word_left),
        .o_word_top    (o_word_top),
        .o_word_width  (o_word_width),
        .o_word_height (o_word_height),
        .o_word_chars  (o_word_chars),
        .o_last_word   (o_last_word),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Word predictor
    // ------------------------------------------------------------------

    // A break stands before a box whose gap exceeds either neighbor gap
    // by more than the margin. Gaps are signed and compared as integers.
    function automatic bit gap_splits(input int cur, input int prev, input int nxt);
        return (cur > prev + int'(margin_now)) || (cur > nxt + int'(margin_now));
    endfunction

    // Union of the open word with one more box, or a fresh word.
    function automatic t_box widen(input logic live, input t_box acc, input t_char c);
        t_box            nb;
        logic [ExtW-1:0] rgt;
        logic [ExtW-1:0] bot;
        rgt = {1'b0, c.x} + {1'b0, c.w};
        bot = {1'b0, c.y} + {1'b0, c.h};
        if (!live) begin
            nb.left   = c.x;
            nb.top    = c.y;
            nb.right  = rgt;
            nb.bottom = bot;
            nb.count  = 8'd1;
        end else begin
            nb.left   = (c.x < acc.left) ? c.x : acc.left;
            nb.top    = (c.y < acc.top) ? c.y : acc.top;
            nb.right  = (rgt > acc.right) ? rgt : acc.right;
            nb.bottom = (bot > acc.bottom) ? bot : acc.bottom;
            // The count sticks at its all-ones value.
            nb.count  = (&acc.count) ? acc.count : acc.count + 8'd1;
        end
        return nb;
    endfunction

    // Append one word to the list of words still owed.
    task automatic owe_word(input t_word wd);
        words_due = {words_due, wd};
    endtask

    task automatic close_word(input logic last);
        t_word wd;
        if (word_live) begin
            wd.left   = word_acc.left;
            wd.top    = word_acc.top;
            wd.width  = word_acc.right - {1'b0, word_acc.left};
            wd.height = word_acc.bottom - {1'b0, word_acc.top};
            wd.chars  = word_acc.count;
            wd.last   = last;
            owe_word(wd);
            word_live = 1'b0;
        end
    endtask

    task automatic clear_line_state();
        parked_live = 1'b0;
        parked_box  = '0;
        parked_gap  = '0;
        prior_gap   = LONE_GAP;
        word_live   = 1'b0;
        word_acc    = '0;
    endtask

    // Advance the predictor by one accepted box and queue any words it
    // closes.
    task automatic segment_box(input t_char c);
        int gap;
        int nxt;
        gap = 0;
        if (parked_live) begin
            gap = int'(c.x) - (int'(parked_box.x) + int'(parked_box.w));
            if (gap_splits(int'(parked_gap), int'(prior_gap), gap))
                close_word(1'b0);
            word_acc  = widen(word_live, word_acc, parked_box);
            word_live = 1'b1;
            prior_gap = parked_gap;
        end
        if (c.line_end) begin
            // A lone box compares against a very large next gap.
            nxt = parked_live ? gap : int'(LONE_GAP);
            if (gap_splits(gap, int'(prior_gap), nxt))
                close_word(1'b0);
            word_acc  = widen(word_live, word_acc, c);
            word_live = 1'b1;
            close_word(1'b1);
            clear_line_state();
        end else begin
            parked_live = 1'b1;
            parked_box  = c;
            parked_gap  = GapW'(gap);
        end
    endtask

    // ------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------

    // Offer one box and return in the time step of its transfer. Valid is
    // left high so that the next call can present the following box in the
    // same step; callers that pause lower it themselves.
    task automatic send_box(input t_char c);
        int idle;
        idle = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT)
                idle++;
        end
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_char_x      <= c.x;
        i_char_y      <= c.y;
        i_char_width  <= c.w;
        i_char_height <= c.h;
        i_line_end    <= c.line_end;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic offer_box(input t_char c);
        send_box(c);
        segment_box(c);
    endtask

    // Stop offering and wait until every owed word has come out, then wait out
    // DRAIN_CYCLES in case the last box was still being worked on.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    // Optionally write gap_margin, then read it back. The read keeps psel
    // high straight out of the write so no signal is assigned twice in one
    // step.
    task automatic margin_access(input bit do_write, input logic [CntW-1:0] value);
        if (do_write) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_GAP_MARGIN;
            pwdata  <= {24'b0, value};
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            margin_now = value;
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_GAP_MARGIN;
        @(posedge i_clk);
        penable <= 1'b1;
        // Sample the read data mid-access, away from any clock edge.
        @(negedge i_clk);
        if (prdata !== {24'b0, margin_now}) begin
            $display("%0t: gap_margin read back, expected %0d, got %0d",
                     $time, margin_now, prdata);
            fail_count++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random text lines
    // ------------------------------------------------------------------

    // Mostly well-formed lines: boxes left to right with tight gaps, word
    // gaps and overlaps, line_end on the last box. noise_pct of the boxes
    // are fully random, with line_end at random, to break the sequences.
    task automatic random_lines(input int n_boxes, input int noise_pct);
        int    sent;
        int    len;
        int    k;
        int    nx;
        int    pr;
        int    ybase;
        bit    line_open;
        t_char c;
        sent      = 0;
        line_open = 1'b0;
        while (sent < n_boxes) begin
            len   = $urandom_range(1, 12);
            pr    = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 4095))
                                                : int'($urandom_range(0, 300));
            ybase = $urandom_range(0, 4000);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < noise_pct) begin
                    c.x        = CoordW'($urandom_range(0, 4095));
                    c.y        = CoordW'($urandom_range(0, 4095));
                    c.w        = CoordW'($urandom_range(0, 4095));
                    c.h        = CoordW'($urandom_range(0, 4095));
                    c.line_end = ($urandom_range(0, 3) == 0);
                end else begin
                    if (k == 0) begin
                        nx = pr;
                    end else begin
                        case ($urandom_range(0, 5))
                            0: nx = pr - int'($urandom_range(1, 12));
                            1, 2: nx = pr + int'($urandom_range(8, 60));
                            default: nx = pr + int'($urandom_range(0, 4));
                        endcase
                    end
                    if (nx < 0 || nx > 4095)
                        nx = $urandom_range(0, 4095);
                    c.x        = nx[CoordW-1:0];
                    c.y        = ($urandom_range(0, 15) == 0)
                                 ? CoordW'($urandom_range(0, 4095))
                                 : CoordW'(ybase + int'($urandom_range(0, 8)));
                    c.w        = ($urandom_range(0, 15) == 0)
                                 ? CoordW'($urandom_range(0, 4095))
                                 : CoordW'($urandom_range(1, 40));
                    c.h        = ($urandom_range(0, 15) == 0)
                                 ? CoordW'($urandom_range(0, 4095))
                                 : CoordW'($urandom_range(1, 60));
                    c.line_end = (k == len - 1);
                end
                offer_box(c);
                pr        = int'(c.x) + int'(c.w);
                line_open = !c.line_end;
                sent++;
            end
        end
        // Leave the block with no partial line before any register write.
        if (line_open) begin
            c.x        = CoordW'($urandom_range(0, 4095));
            c.y        = CoordW'($urandom_range(0, 4095));
            c.w        = CoordW'($urandom_range(1, 40));
            c.h        = CoordW'($urandom_range(1, 60));
            c.line_end = 1'b1;
            offer_box(c);
        end
    endtask

    // ------------------------------------------------------------------
    // Output channel: receiver and checker
    // ------------------------------------------------------------------

    // Receiver: random stalls, none while calm, and one long hold-off on
    // request while the sender keeps offering.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic int field_differs(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Every word transfer is matched against the oldest owed word.
    always @(posedge i_clk) begin
        t_word want;
        int    bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (words_due.size() == 0) begin
                $display({"%0t: unexpected word, expected none, got left %0d top %0d",
                          " width %0d height %0d chars %0d last %0d"},
                         $time, o_word_left, o_word_top, o_word_width, o_word_height,
                         o_word_chars, o_last_word);
                fail_count++;
            end else begin
                want = words_due.pop_front();
                bad  = field_differs("word_left", int'(want.left), int'(o_word_left))
                     + field_differs("word_top", int'(want.top), int'(o_word_top))
                     + field_differs("word_width", int'(want.width), int'(o_word_width))
                     + field_differs("word_height", int'(want.height), int'(o_word_height))
                     + field_differs("word_chars", int'(want.chars), int'(o_word_chars))
                     + field_differs("last_word", int'(want.last), int'(o_last_word));
                if (bad != 0)
                    fail_count++;
            end
        end
    end

    // Watchdog: give up when neither channel has moved for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------

    initial begin
        int    r;
        int    n0;
        margin_now = MARGIN_RESET;
        clear_line_state();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The register must come out of reset at its default.
        margin_access(1'b0, margin_now);

        // Directed table at the reset margin. Hand-typed words replace what
        // the predictor queued for that row; its state still advances.
        for (r = 0; r < NUM_ROWS; r++) begin
            send_box(seg_rows[r].box);
            n0 = words_due.size();
            segment_box(seg_rows[r].box);
            if (seg_rows[r].typed) begin
                while (words_due.size() > n0)
                    void'(words_due.pop_back());
                owe_word(seg_rows[r].word);
            end
        end

        // Zero margin: any gap growth at all breaks a word.
        settle();
        margin_access(1'b1, 8'd0);
        random_lines(50, 10);

        // Largest margin: breaks only on huge gaps.
        settle();
        margin_access(1'b1, 8'd255);
        random_lines(40, 10);

        // Random margin: first a stretch with no idling on either side,
        // then the long receiver hold-off while boxes keep coming.
        settle();
        margin_access(1'b1, 8'($urandom_range(1, 254)));
        calm = 1'b1;
        random_lines(40, 0);
        calm = 1'b0;
        hold_req = 1'b1;
        random_lines(40, 10);

        // Back to the default margin with noisier lines.
        settle();
        margin_access(1'b1, MARGIN_RESET);
        random_lines(30, 25);

        settle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
